@@ rtl/core/spisr_pkg.sv @@
package spisr_pkg;

  // Receive store geometry
  localparam int BUFFER_DEPTH = 256;
  localparam int BUF_AW = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = 9;
  localparam int BYTE_W = 8;

  // Input item kinds (carried on in_tuser)
  localparam logic [2:0] CMD_BYTE   = 3'd0;
  localparam logic [2:0] CMD_END    = 3'd1;
  localparam logic [2:0] CMD_BUFWR  = 3'd2;
  localparam logic [2:0] CMD_ARM    = 3'd3;
  localparam logic [2:0] CMD_HOST   = 3'd4;
  localparam logic [2:0] CMD_STATS  = 3'd5;

  // Transmit actions (carried on out_tuser)
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_NONE    = 2'd0;
  localparam logic [1:0] ST_OK      = 2'd1;
  localparam logic [1:0] ST_NODATA  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_OP_AVAIL = 2'd0;
  localparam logic [1:0] REG_OP_READ  = 2'd1;
  localparam logic [1:0] REG_OP_SNR   = 2'd2;
  localparam logic [1:0] REG_OP_RSSI  = 2'd3;

  // Byte positions inside a frame
  localparam logic [1:0] POS_FIRST  = 2'd1;
  localparam logic [1:0] POS_SECOND = 2'd2;
  localparam logic [1:0] POS_LAST   = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [BYTE_W-1:0] data;
    logic [1:0]        status;
    logic              poll;
    logic              led_off;
    logic              from_ram;
  } result_t;

endpackage

@@ rtl/core/spisr_ram.sv @@
module spisr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/spi_slave_command_responder_unit.sv @@
// Slave-side responder for a byte-wide SPI command protocol.
// Input channel (in_*): one item per event. in_tuser holds the item kind:
// a byte received from the master, frame end, receive buffer write, buffer
// arm, host status or a radio stats update. in_tdata carries the operands.
// Result channel (out_*): exactly one item per input item, in order.
// out_tuser says what to do with the transmit register; out_tdata carries
// the byte, the status code, the poll request and the LED-off flag.
// out_tvalid rises in the cycle after acceptance. One item is taken
// every cycle while the receiver keeps up; the buffer read for a READ
// command is issued in the accept cycle and its registered RAM output
// is muxed onto out_tdata in place of the result register's data byte.
// The receive buffer is a 256 x 8 single-write, single-read RAM; it is not
// cleared by reset, and a READ of a byte never written returns garbage.
// Reset (rst_n low, synchronous) ends any frame, clears the count and the
// held radio values and restores the default opcodes.
// When out_tready is low with a result pending, in_tready drops and all state
// but the opcodes holds until the result is taken. Opcode writes through cfg_*
// take effect at once and should only be made while the block is idle.
module spi_slave_command_responder_unit
  import spisr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // cmd[2:0]
  input  logic [2:0]  in_tuser,
  // rx_byte[7:0], buf_index[15:8], buf_data[23:16], buf_length[32:24],
  // status_byte[40:33], snr_value[48:41], rssi_value[56:49],
  // shield_value[64:57], zero fill above
  input  logic [71:0] in_tdata,

  output logic        out_tvalid,
  input  logic        out_tready,
  // tx_action[1:0]
  output logic [1:0]  out_tuser,
  // tx_byte[7:0], status_code[9:8], poll_request[10], led_off[11],
  // zero fill above
  output logic [15:0] out_tdata,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [BYTE_W-1:0] rx_byte, buf_index, buf_data, status_byte;
  logic [BYTE_W-1:0] snr_value, rssi_value, shield_value;
  logic [CNT_W-1:0]  buf_length;

  assign rx_byte      = in_tdata[7:0];
  assign buf_index    = in_tdata[15:8];
  assign buf_data     = in_tdata[23:16];
  assign buf_length   = in_tdata[32:24];
  assign status_byte  = in_tdata[40:33];
  assign snr_value    = in_tdata[48:41];
  assign rssi_value   = in_tdata[56:49];
  assign shield_value = in_tdata[64:57];

  logic [BYTE_W-1:0] op_avail_r, op_read_r, op_snr_r, op_rssi_r;
  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] frame_cmd_r, frame_cmd_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic              read_failed_r, read_failed_nxt;
  logic [CNT_W-1:0]  remaining_r, remaining_nxt;
  logic [CNT_W-1:0]  armed_r, armed_nxt;
  logic [BYTE_W-1:0] snr_r, snr_nxt, rssi_r, rssi_nxt, shield_r, shield_nxt;

  logic              res_valid_r;
  result_t           res_r, res_nxt;

  logic              accept;
  logic              ram_we, ram_re;
  logic [BUF_AW-1:0] ram_raddr;
  logic [CNT_W-1:0]  read_offset;
  logic [BYTE_W-1:0] ram_rdata;

  assign in_tready = !res_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Position of the next unread byte; the count never exceeds the armed length.
  assign read_offset = armed_r - remaining_r;
  assign ram_raddr   = read_offset[BUF_AW-1:0];

  always_comb begin
    in_frame_nxt    = in_frame_r;
    frame_cmd_nxt   = frame_cmd_r;
    pos_nxt         = pos_r;
    read_failed_nxt = read_failed_r;
    remaining_nxt   = remaining_r;
    armed_nxt       = armed_r;
    snr_nxt         = snr_r;
    rssi_nxt        = rssi_r;
    shield_nxt      = shield_r;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    res_nxt         = '0;

    case (in_tuser)
      CMD_BYTE: begin
        res_nxt.action = ACT_BYTE;
        if (!in_frame_r) begin
          in_frame_nxt    = 1'b1;
          frame_cmd_nxt   = rx_byte;
          pos_nxt         = POS_FIRST;
          read_failed_nxt = 1'b0;
          res_nxt.data    = shield_r;
        end else begin
          if (pos_r != POS_LAST) begin
            pos_nxt = pos_r + 2'd1;
          end
          if (frame_cmd_r == op_avail_r) begin
            if (pos_r == POS_FIRST) begin
              res_nxt.data = {{(2*BYTE_W-CNT_W){1'b0}}, remaining_r[CNT_W-1:BYTE_W]};
            end else if (pos_r == POS_SECOND) begin
              res_nxt.data = remaining_r[BYTE_W-1:0];
            end
          end else if (frame_cmd_r == op_read_r) begin
            if (pos_r == POS_FIRST) begin
              if (remaining_r != '0) begin
                ram_re           = 1'b1;
                res_nxt.from_ram = 1'b1;
                remaining_nxt    = remaining_r - CNT_W'(1);
                read_failed_nxt  = 1'b0;
                res_nxt.led_off  = (remaining_r == CNT_W'(1));
              end else begin
                read_failed_nxt = 1'b1;
              end
            end
          end else if (frame_cmd_r == op_snr_r) begin
            if (pos_r == POS_FIRST) begin
              res_nxt.data = snr_r;
            end
          end else if (frame_cmd_r == op_rssi_r) begin
            if (pos_r == POS_FIRST) begin
              res_nxt.data = rssi_r;
            end
          end else begin
            res_nxt.action = ACT_NONE;
          end
        end
      end
      CMD_END: begin
        if (in_frame_r) begin
          in_frame_nxt   = 1'b0;
          res_nxt.action = ACT_STATUS;
          if (frame_cmd_r == op_read_r) begin
            res_nxt.status = read_failed_r ? ST_NODATA : ST_OK;
          end else if (frame_cmd_r == op_avail_r) begin
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.poll = 1'b1;
          end
        end
      end
      CMD_BUFWR: begin
        // The index field spans the whole store, so every write lands.
        ram_we = 1'b1;
      end
      CMD_ARM: begin
        if (buf_length > CNT_W'(BUFFER_DEPTH)) begin
          armed_nxt = CNT_W'(BUFFER_DEPTH);
        end else begin
          armed_nxt = buf_length;
        end
        remaining_nxt = armed_nxt;
      end
      CMD_HOST: begin
        res_nxt.action = ACT_BYTE;
        res_nxt.data   = status_byte;
      end
      CMD_STATS: begin
        snr_nxt    = snr_value;
        rssi_nxt   = rssi_value;
        shield_nxt = shield_value;
      end
      default: begin
      end
    endcase
  end

  spisr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (accept && ram_we),
    .waddr(buf_index[BUF_AW-1:0]),
    .wdata(buf_data),
    .re   (accept && ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_avail_r    <= 8'd1;
      op_read_r     <= 8'd2;
      op_snr_r      <= 8'd3;
      op_rssi_r     <= 8'd4;
      in_frame_r    <= 1'b0;
      frame_cmd_r   <= '0;
      pos_r         <= '0;
      read_failed_r <= 1'b0;
      remaining_r   <= '0;
      armed_r       <= '0;
      snr_r         <= '0;
      rssi_r        <= '0;
      shield_r      <= '0;
      res_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OP_AVAIL: op_avail_r <= cfg_wdata;
          REG_OP_READ:  op_read_r  <= cfg_wdata;
          REG_OP_SNR:   op_snr_r   <= cfg_wdata;
          REG_OP_RSSI:  op_rssi_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (accept) begin
        in_frame_r    <= in_frame_nxt;
        frame_cmd_r   <= frame_cmd_nxt;
        pos_r         <= pos_nxt;
        read_failed_r <= read_failed_nxt;
        remaining_r   <= remaining_nxt;
        armed_r       <= armed_nxt;
        snr_r         <= snr_nxt;
        rssi_r        <= rssi_nxt;
        shield_r      <= shield_nxt;
        res_valid_r   <= 1'b1;
      end else if (out_tready) begin
        res_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tuser  = res_r.action;
  assign out_tdata  = {4'b0, res_r.led_off, res_r.poll, res_r.status,
                       res_r.from_ram ? ram_rdata : res_r.data};

  // The outstanding count can never pass the armed length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    remaining_r <= armed_r)
    else $error("receive count exceeds armed length");

  a_armed_bound: assert property (@(posedge clk) disable iff (!rst_n)
    armed_r <= CNT_W'(BUFFER_DEPTH))
    else $error("armed length exceeds buffer depth");

  // A buffered byte is only ever delivered as a data load.
  a_ram_action: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.from_ram) |-> (res_r.action == ACT_BYTE))
    else $error("buffer byte without a data load");

  a_status_action: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && (res_r.status != ST_NONE || res_r.poll)) |->
      (res_r.action == ACT_STATUS))
    else $error("status or poll without a status load");

  // A stalled result blocks the next item and keeps the state unchanged.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_tready) |=> ($stable(remaining_r) && $stable(in_frame_r)))
    else $error("state moved under a stalled result");

endmodule
